// ===== rtl/keypad_ir_pulse_count_transmitter_unit_assert.svh =====
// Assertion macros used by the keypad IR transmitter checker.
// Needs nothing else; included by rtl/kpir_checker.sv.
`ifndef KEYPAD_IR_PULSE_COUNT_TRANSMITTER_UNIT_ASSERT_SVH
`define KEYPAD_IR_PULSE_COUNT_TRANSMITTER_UNIT_ASSERT_SVH

// Clocked assertion with an asynchronous active-low reset and a fixed message.
`define KPIR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("kpir assertion failed");

// Same, with a caller-given message string.
`define KPIR_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// ===== rtl/kpir_pkg.sv =====
// Shared types, register indexes and the segment table of the keypad IR transmitter.
// No dependencies; used by the top level and by its checker.
package kpir_pkg;

	localparam int unsigned ColW   = 4;
	localparam int unsigned RowW   = 4;
	localparam int unsigned TickW  = 16;
	localparam int unsigned MsW    = 8;
	localparam int unsigned SegW   = 8;
	localparam int unsigned PulseW = 5;
	localparam int unsigned KeyW   = 4;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned InTdataW  = 8;
	localparam int unsigned OutTdataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TICKS_PER_MS = 3'd0,
		REG_DEBOUNCE_MS  = 3'd1,
		REG_START_MS     = 3'd2,
		REG_MARK_MS      = 3'd3,
		REG_SPACE_MS     = 3'd4,
		REG_TAIL_MS      = 3'd5
	} reg_idx_t;

	localparam logic [TickW-1:0] TicksPerMsRst = 16'd80;
	localparam logic [MsW-1:0]   DebounceMsRst = 8'd10;
	localparam logic [MsW-1:0]   StartMsRst    = 8'd3;
	localparam logic [MsW-1:0]   MarkMsRst     = 8'd1;
	localparam logic [MsW-1:0]   SpaceMsRst    = 8'd1;
	localparam logic [MsW-1:0]   TailMsRst     = 8'd10;

	typedef enum logic [7:0] {
		PH_SCAN     = 8'b0000_0001,
		PH_DEBOUNCE = 8'b0000_0010,
		PH_RELEASE  = 8'b0000_0100,
		PH_DROP     = 8'b0000_1000,
		PH_START    = 8'b0001_0000,
		PH_SPACE    = 8'b0010_0000,
		PH_MARK     = 8'b0100_0000,
		PH_TAIL     = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [TickW-1:0] ticks_per_ms;
		logic [MsW-1:0]   debounce_ms;
		logic [MsW-1:0]   start_ms;
		logic [MsW-1:0]   mark_ms;
		logic [MsW-1:0]   space_ms;
		logic [MsW-1:0]   tail_ms;
	} cfg_t;

	// Packed in tdata order: the first field sits in the highest bits.
	typedef struct packed {
		logic            busy_res;
		logic [SegW-1:0] segments;
		logic            ir_out;
		logic [RowW-1:0] row_drive;
	} result_t;

	localparam int unsigned ResW = $bits(result_t);

	function automatic logic [SegW-1:0] seg_lut(input logic [KeyW-1:0] key);
		logic [SegW-1:0] s;
		case (key)
			4'd0:    s = 8'h09;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			4'd10:   s = 8'h77;
			4'd11:   s = 8'h7c;
			4'd12:   s = 8'h39;
			4'd13:   s = 8'h5e;
			4'd14:   s = 8'h79;
			default: s = 8'h71;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/keypad_ir_pulse_count_transmitter_unit.sv =====
// Keypad scanner with IR pulse-count transmitter, top level.
// Depends on rtl/kpir_pkg.sv.
//
// Usage: every beat on the s_ channel is one carrier tick and carries the four
// active-low column lines sensed on the row that the previous result drove.
// Each input beat yields exactly one result beat on the m_ channel with the
// next row drive, the IR level for this tick, the latched segment pattern and
// a busy flag. The cfg_ channel writes the six timing registers; cfg_ready is
// always high and writes belong in idle periods only.
// A taken beat's result passes the single state update between the phase/timer
// registers and a two-entry result buffer, is registered there and offered on
// m_ once earlier ones have left. Throughput is one beat per clock while the
// buffer has room. On a receiver stall, the buffer holds up to two results;
// s_tready drops only while both entries are full; none is lost or reordered.
// Reset (arst_n low) puts the block in the scan phase on row 0 with all timers
// and the segment latch cleared, loads the default register values and empties
// the result buffer.
module keypad_ir_pulse_count_transmitter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [kpir_pkg::InTdataW-1:0]       s_tdata,   // [3:0] col_lines
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [3:0] row_drive, [4] ir_out, [12:5] segments, [13] busy_res
	output logic [kpir_pkg::OutTdataW-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kpir_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [kpir_pkg::CfgDataW-1:0]       cfg_data
);
	import kpir_pkg::*;

	typedef struct packed {
		phase_t            ph;
		logic [MsW-1:0]    ms;
		logic [PulseW-1:0] pulses;
	} xmit_t;

	function automatic xmit_t enter_tail(input cfg_t c);
		xmit_t r;
		r.ms     = c.tail_ms;
		r.pulses = '0;
		r.ph     = (c.tail_ms != '0) ? PH_TAIL : PH_SCAN;
		return r;
	endfunction

	// Enter the space of a counting pulse, skipping zero-length phases.
	function automatic xmit_t enter_pulse(input cfg_t c, input logic [PulseW-1:0] p);
		xmit_t r;
		r = enter_tail(c);
		if (c.space_ms != '0) begin
			r.ph = PH_SPACE; r.ms = c.space_ms; r.pulses = p;
		end else if (c.mark_ms != '0) begin
			r.ph = PH_MARK; r.ms = c.mark_ms; r.pulses = p;
		end
		return r;
	endfunction

	function automatic xmit_t after_mark(input cfg_t c, input logic [PulseW-1:0] p);
		logic [PulseW-1:0] p2;
		xmit_t r;
		p2 = p - 1'b1;
		if (p2 != '0) r = enter_pulse(c, p2);
		else r = enter_tail(c);
		return r;
	endfunction

	function automatic xmit_t enter_start(input cfg_t c, input logic [PulseW-1:0] p);
		xmit_t r;
		if (c.start_ms != '0) begin
			r.ph = PH_START; r.ms = c.start_ms; r.pulses = p;
		end else if (p != '0) begin
			r = enter_pulse(c, p);
		end else begin
			r = enter_tail(c);
		end
		return r;
	endfunction

	cfg_t              cfg_q;
	phase_t            phase_q, n_phase;
	logic [1:0]        row_q, n_row;
	logic [KeyW-1:0]   key_q, n_key;
	logic [PulseW-1:0] pulses_q, n_pulses;
	logic [MsW-1:0]    ms_q, n_ms;
	logic [TickW-1:0]  tick_q, n_tick;
	logic              carrier_q, n_carrier;
	logic [SegW-1:0]   seg_q, n_seg;

	logic [ColW-1:0]   low;
	logic [TickW-1:0]  tick_inc, tick_after;
	logic              tick_wrap;
	logic [MsW-1:0]    ms_dec;
	logic              go;
	xmit_t             nx;
	logic              ir;
	logic [1:0]        col;
	result_t           res;

	logic    in_beat, out_beat;
	result_t buf_q [2];
	logic    wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_ms <= TicksPerMsRst;
			cfg_q.debounce_ms  <= DebounceMsRst;
			cfg_q.start_ms     <= StartMsRst;
			cfg_q.mark_ms      <= MarkMsRst;
			cfg_q.space_ms     <= SpaceMsRst;
			cfg_q.tail_ms      <= TailMsRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TICKS_PER_MS: cfg_q.ticks_per_ms <= cfg_data;
				REG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= cfg_data[MsW-1:0];
				REG_START_MS:     cfg_q.start_ms     <= cfg_data[MsW-1:0];
				REG_MARK_MS:      cfg_q.mark_ms      <= cfg_data[MsW-1:0];
				REG_SPACE_MS:     cfg_q.space_ms     <= cfg_data[MsW-1:0];
				REG_TAIL_MS:      cfg_q.tail_ms      <= cfg_data[MsW-1:0];
				default: ;
			endcase
		end
	end

	// Millisecond timer: one tick counted, a millisecond taken off on wrap.
	assign low        = ~s_tdata[ColW-1:0];
	assign tick_inc   = tick_q + 1'b1;
	assign tick_wrap  = tick_inc >= cfg_q.ticks_per_ms;
	assign tick_after = tick_wrap ? '0 : tick_inc;
	assign ms_dec     = (tick_wrap && ms_q != '0) ? ms_q - 1'b1 : ms_q;
	assign col        = {low[3] | low[2], low[3] | low[1]};

	always_comb begin
		n_phase   = phase_q;
		n_row     = row_q;
		n_key     = key_q;
		n_pulses  = pulses_q;
		n_ms      = ms_q;
		n_tick    = tick_q;
		n_carrier = carrier_q;
		n_seg     = seg_q;
		ir        = 1'b0;
		go        = 1'b0;
		nx        = enter_tail(cfg_q);
		unique case (phase_q)
			PH_SCAN: begin
				if (low != '0) begin
					n_phase = PH_DEBOUNCE;
					n_ms    = cfg_q.debounce_ms;
					n_tick  = '0;
				end else begin
					n_row = row_q + 1'b1;
				end
			end
			PH_DEBOUNCE: begin
				if (ms_q != '0) begin
					n_tick = tick_after;
					n_ms   = ms_dec;
				end else if (low == '0) begin
					go    = 1'b1;
					nx.ph = PH_SCAN;
					nx.ms = ms_q;
					nx.pulses = pulses_q;
				end else if ((low & (low - 1'b1)) == '0) begin
					n_key   = {row_q, col};
					n_phase = PH_RELEASE;
				end else begin
					n_phase = PH_DROP;
				end
			end
			PH_RELEASE: begin
				if (low == '0) begin
					n_seg = seg_lut(key_q);
					go    = 1'b1;
					nx    = enter_start(cfg_q, {1'b0, key_q} + 1'b1);
				end
			end
			PH_DROP: begin
				if (low == '0) begin
					go    = 1'b1;
					nx.ph = PH_SCAN;
					nx.ms = ms_q;
					nx.pulses = pulses_q;
				end
			end
			PH_START, PH_SPACE, PH_MARK, PH_TAIL: begin
				if (phase_q == PH_START || phase_q == PH_MARK) begin
					n_carrier = ~carrier_q;
					ir        = ~carrier_q;
				end
				n_tick = tick_after;
				n_ms   = ms_dec;
				if (ms_dec == '0) begin
					go = 1'b1;
					case (phase_q)
						PH_START: begin
							if (pulses_q != '0) nx = enter_pulse(cfg_q, pulses_q);
							else nx = enter_tail(cfg_q);
						end
						PH_SPACE: begin
							if (cfg_q.mark_ms != '0) begin
								nx.ph = PH_MARK; nx.ms = cfg_q.mark_ms;
								nx.pulses = pulses_q;
							end else begin
								nx = after_mark(cfg_q, pulses_q);
							end
						end
						PH_MARK: nx = after_mark(cfg_q, pulses_q);
						default: begin
							nx.ph = PH_SCAN; nx.ms = ms_dec; nx.pulses = pulses_q;
						end
					endcase
				end
			end
			default: n_phase = PH_SCAN;
		endcase
		// A phase change resets the tick counter and carrier; going back to
		// scanning also moves on to the next row and leaves the ms count alone.
		if (go) begin
			n_phase   = nx.ph;
			n_pulses  = nx.pulses;
			n_tick    = '0;
			n_carrier = 1'b0;
			if (nx.ph == PH_SCAN) n_row = row_q + 1'b1;
			else n_ms = nx.ms;
		end
	end

	assign res.row_drive = ~(RowW'(1) << n_row);
	assign res.ir_out    = ir;
	assign res.segments  = n_seg;
	assign res.busy_res  = (n_phase != PH_SCAN);

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SCAN;
			row_q     <= '0;
			key_q     <= '0;
			pulses_q  <= '0;
			ms_q      <= '0;
			tick_q    <= '0;
			carrier_q <= 1'b0;
			seg_q     <= '0;
		end else if (in_beat) begin
			phase_q   <= n_phase;
			row_q     <= n_row;
			key_q     <= n_key;
			pulses_q  <= n_pulses;
			ms_q      <= n_ms;
			tick_q    <= n_tick;
			carrier_q <= n_carrier;
			seg_q     <= n_seg;
		end
	end

	// Two-entry result buffer keeps the input side moving while m_ stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (in_beat) wr_ptr_q <= ~wr_ptr_q;
			if (out_beat) rd_ptr_q <= ~rd_ptr_q;
			if (in_beat && !out_beat) cnt_q <= cnt_q + 1'b1;
			else if (!in_beat && out_beat) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) buf_q[wr_ptr_q] <= res;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {{(OutTdataW - ResW){1'b0}}, buf_q[rd_ptr_q]};

endmodule

// ===== rtl/kpir_checker.sv =====
// Port-level checker for the keypad IR transmitter, bound to the top level.
// Depends on rtl/kpir_pkg.sv and rtl/keypad_ir_pulse_count_transmitter_unit_assert.svh.
`include "keypad_ir_pulse_count_transmitter_unit_assert.svh"

module kpir_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [kpir_pkg::InTdataW-1:0]   s_tdata,   // [3:0] col_lines
	input logic                            m_tvalid,
	input logic                            m_tready,
	// [3:0] row_drive, [4] ir_out, [12:5] segments, [13] busy_res
	input logic [kpir_pkg::OutTdataW-1:0]  m_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [kpir_pkg::CfgIdxW-1:0]    cfg_index,
	input logic [kpir_pkg::CfgDataW-1:0]   cfg_data
);
	import kpir_pkg::*;

	result_t out_res;
	assign out_res = result_t'(m_tdata[ResW-1:0]);

	// Every accepted input beat leaves a result waiting on the next cycle.
	`KPIR_ASSERT(a_in_gives_out, clk, arst_n, s_tvalid && s_tready |=> m_tvalid)

	// Exactly one row is driven low in every result beat.
	`KPIR_ASSERT(a_row_one_cold, clk, arst_n, m_tvalid |-> $onehot(~out_res.row_drive))

	// Back-pressure on the input only when results are waiting.
	`KPIR_ASSERT_MSG(a_full_has_out, clk, arst_n, !s_tready |-> m_tvalid, "stall with empty output")

	`KPIR_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

bind keypad_ir_pulse_count_transmitter_unit kpir_checker u_kpir_checker (.*);
